### design/ppw_pkg.sv
package ppw_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 24;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int WIND_W       = CNT_W + 1;
    localparam int ENTRY_W      = 2 * COORD_BITS;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_TEST   = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_FEW  = 2'd2;

    localparam logic signed [2:0] STEP_M3 = -3'sd3;
    localparam logic signed [2:0] STEP_P3 = 3'sd3;
    localparam logic signed [2:0] STEP_M2 = -3'sd2;
    localparam logic signed [2:0] STEP_P2 = 3'sd2;

    // quadrant table indexed [y < 0][x < 0]
    localparam logic [1:0] QUAD_TAB [2][2] = '{'{2'd0, 2'd1}, '{2'd3, 2'd2}};

    typedef struct packed {
        logic [1:0]                   command;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
    } req_t;

    typedef struct packed {
        logic       inside_res;
        logic [1:0] status;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    function automatic logic [1:0] quad_of(input logic x_neg, input logic y_neg);
        return QUAD_TAB[y_neg][x_neg];
    endfunction

endpackage

### design/point_in_polygon_winding_top.sv
// Polygon store with a winding-number point test. Clear and append finish in the
// cycle they are accepted and return one result beat each, so they stream at one
// beat per cycle while the result side keeps up. A test on n >= 3 stored vertices
// walks the vertex memory through its single read port, one vertex per cycle,
// starting with the last vertex; no new beat is taken until its result appears. Tests
// on fewer than three vertices answer at once with status 2.
module point_in_polygon_winding_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ppw_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ppw_pkg::rsp_t  rsp
);
    import ppw_pkg::*;

    logic [ENTRY_W-1:0] mem [MAX_VERTICES];

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_m1;
    logic [ADDR_W-1:0] issue_reg;

    logic signed [COORD_BITS-1:0] tx_reg, ty_reg;

    logic              req_acc;
    logic              wr_en;
    logic              rd_en, rd_first, rd_last;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_free;

    // stage 1: memory read data
    logic               v1_reg, first1_reg, last1_reg;
    logic [ENTRY_W-1:0] rd_data_reg;

    // stage 2: translated vertex
    logic                     v2_reg, first2_reg, last2_reg;
    logic signed [DIFF_W-1:0] cx_reg, cy_reg, cx_next, cy_next;
    logic [1:0]               cq_reg;
    logic signed [DIFF_W-1:0] px_reg, py_reg;
    logic [1:0]               pq_reg;

    // stage 3: cross products and quadrant step
    logic                     v3_reg, last3_reg;
    logic signed [PROD_W-1:0] pa_reg, pb_reg;
    logic signed [2:0]        dq_reg;

    logic signed [WIND_W-1:0] w_reg, w_next;
    logic                     ge;
    logic                     done;

    logic short_test;
    logic rsp_valid_reg;
    rsp_t rsp_reg;

    assign req_acc    = req_valid && !req_stall;
    assign count_m1   = count_reg - 1'b1;
    assign short_test = count_reg < CNT_W'(3);
    assign wr_en      = req_acc && (req.command == CMD_APPEND)
                        && (count_reg < CNT_W'(MAX_VERTICES));
    assign out_free   = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (req_acc && req.command == CMD_TEST && !short_test)
                    state_next = ST_RUN;
            ST_RUN:
                if (issue_reg == count_m1[ADDR_W-1:0])
                    state_next = ST_DRAIN;
            ST_DRAIN:
                if (done)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_stall = 1'b1;
        rd_en     = 1'b0;
        rd_first  = 1'b0;
        rd_last   = 1'b0;
        rd_addr   = issue_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = !out_free;
                rd_en     = req_valid && out_free && req.command == CMD_TEST && !short_test;
                rd_first  = 1'b1;
                rd_addr   = count_m1[ADDR_W-1:0];
            end
            ST_RUN:
            begin
                rd_en   = 1'b1;
                rd_last = issue_reg == count_m1[ADDR_W-1:0];
            end
            ST_DRAIN:
                req_stall = 1'b1;
            default:
                req_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            issue_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_acc && req.command == CMD_CLEAR)
                count_reg <= '0;
            else if (wr_en)
                count_reg <= count_reg + 1'b1;
            if (state_reg == ST_RUN)
                issue_reg <= issue_reg + 1'b1;
            else
                issue_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[ADDR_W-1:0]] <= {req.point_x, req.point_y};
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
        if (req_acc)
        begin
            tx_reg <= req.point_x;
            ty_reg <= req.point_y;
        end
    end

    // stage 1 -> 2: translate by the test point
    always_comb
    begin
        cx_next = DIFF_W'($signed(rd_data_reg[ENTRY_W-1:COORD_BITS])) - DIFF_W'(tx_reg);
        cy_next = DIFF_W'($signed(rd_data_reg[COORD_BITS-1:0])) - DIFF_W'(ty_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && !first2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        first1_reg <= rd_first;
        last1_reg  <= rd_last;
        first2_reg <= first1_reg;
        last2_reg  <= last1_reg;
        last3_reg  <= last2_reg;
        if (v1_reg)
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
            cq_reg <= quad_of(cx_next[DIFF_W-1], cy_next[DIFF_W-1]);
        end
        if (v2_reg)
        begin
            px_reg <= cx_reg;
            py_reg <= cy_reg;
            pq_reg <= cq_reg;
            pa_reg <= PROD_W'(px_reg) * PROD_W'(cy_reg);
            pb_reg <= PROD_W'(py_reg) * PROD_W'(cx_reg);
            dq_reg <= $signed({1'b0, cq_reg}) - $signed({1'b0, pq_reg});
        end
    end

    // stage 3: winding accumulation
    assign ge   = pa_reg >= pb_reg;
    assign done = v3_reg && last3_reg;

    always_comb
    begin
        w_next = w_reg;
        unique case (dq_reg)
            STEP_M3: w_next = w_reg + 1'b1;
            STEP_P3: w_next = w_reg - 1'b1;
            STEP_M2: if (ge)  w_next = w_reg + 1'b1;
            STEP_P2: if (!ge) w_next = w_reg - 1'b1;
            default: w_next = w_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
            w_reg <= '0;
        else if (v3_reg)
            w_reg <= w_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if ((req_acc && (req.command != CMD_TEST || short_test)) || done)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            rsp_reg.inside_res <= w_next != '0;
            rsp_reg.status     <= STATUS_OK;
        end
        else if (req_acc)
        begin
            rsp_reg.inside_res <= 1'b0;
            priority if (req.command == CMD_APPEND && !wr_en)
                rsp_reg.status <= STATUS_FULL;
            else if (req.command == CMD_TEST && short_test)
                rsp_reg.status <= STATUS_FEW;
            else
                rsp_reg.status <= STATUS_OK;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### design/ppw_chk.sv
module ppw_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input ppw_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input ppw_pkg::rsp_t rsp
);
    import ppw_pkg::*;

    logic req_acc;
    assign req_acc = req_valid && !req_stall;

    // a stalled result beat stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result beat dropped while stalled");

    // clear and append answer in the next cycle
    a_quick_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && (req.command == CMD_CLEAR || req.command == CMD_APPEND)
        |=> rsp_valid && !rsp.inside_res)
        else $error("clear/append result missing");

    a_append_status: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && req.command == CMD_APPEND
        |=> rsp.status == STATUS_OK || rsp.status == STATUS_FULL)
        else $error("bad append status");

    // inside only ever reported with ok status
    a_inside_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.inside_res |-> rsp.status == STATUS_OK)
        else $error("inside flagged with error status");

endmodule

bind point_in_polygon_winding_top ppw_chk u_ppw_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
